// ===== rtl/hfo_pkg.sv =====
// ----------------------------------------------------------------------------
// hfo_pkg : shared types and constants for the heading-from-offset unit
// Fixed-point formats, the stage payload and the arctangent table.
// ----------------------------------------------------------------------------
package hfo_pkg;

   // CORDIC x/y datapath: offsets are scaled to a magnitude of at most 2^39,
   // CORDIC gain and the first micro-rotation stay below 2^42.
   localparam int XY_WIDTH        = 44;
   localparam int SCALED_MAG_LOG2 = 40;

   // Angle accumulator: centidegrees times 2^16.
   localparam int ACC_WIDTH       = 32;
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int HEADING_WIDTH   = 16;

   localparam logic signed [HEADING_WIDTH-1:0] HEADING_ZERO    = 16'sd0;
   localparam logic signed [HEADING_WIDTH-1:0] QUARTER_TURN    = 16'sd9000;
   localparam logic signed [HEADING_WIDTH-1:0] HALF_TURN       = 16'sd18000;
   localparam logic signed [HEADING_WIDTH-1:0] NEG_HALF_TURN   = -16'sd18000;
   localparam logic signed [HEADING_WIDTH-1:0] NEG_QUARTER_TURN = -16'sd9000;

   localparam logic signed [ACC_WIDTH-1:0] ACC_ZERO      = 32'sd0;
   localparam logic signed [ACC_WIDTH-1:0] ACC_HALF_TURN = 32'sd1179648000;
   localparam logic signed [ACC_WIDTH-1:0] ACC_ROUND     = 32'sd32768;

   // Payload carried from stage to stage.
   typedef struct packed {
      logic signed [XY_WIDTH-1:0]      x;
      logic signed [XY_WIDTH-1:0]      y;
      logic signed [ACC_WIDTH-1:0]     acc;
      logic                            special;
      logic signed [HEADING_WIDTH-1:0] special_heading;
   } hfo_stage_type;

   // atan(2^-i) in centidegrees times 2^16, rounded to nearest.
   function automatic logic signed [ACC_WIDTH-1:0] atan_entry(input logic [4:0] index);
      logic signed [ACC_WIDTH-1:0] value;
      case (index)
         5'd0:    value = 32'sd294912000;
         5'd1:    value = 32'sd174096719;
         5'd2:    value = 32'sd91987925;
         5'd3:    value = 32'sd46694507;
         5'd4:    value = 32'sd23437865;
         5'd5:    value = 32'sd11730358;
         5'd6:    value = 32'sd5866609;
         5'd7:    value = 32'sd2933484;
         5'd8:    value = 32'sd1466764;
         5'd9:    value = 32'sd733385;
         5'd10:   value = 32'sd366693;
         5'd11:   value = 32'sd183346;
         5'd12:   value = 32'sd91673;
         5'd13:   value = 32'sd45837;
         5'd14:   value = 32'sd22918;
         5'd15:   value = 32'sd11459;
         5'd16:   value = 32'sd5730;
         5'd17:   value = 32'sd2865;
         5'd18:   value = 32'sd1432;
         5'd19:   value = 32'sd716;
         5'd20:   value = 32'sd358;
         5'd21:   value = 32'sd179;
         5'd22:   value = 32'sd90;
         5'd23:   value = 32'sd45;
         default: value = 32'sd0;
      endcase
      return value;
   endfunction

endpackage

// ===== rtl/hfo_req_if.sv =====
// ----------------------------------------------------------------------------
// hfo_req_if : request channel of the heading unit
// Valid/ready handshake carrying one x/y offset pair.
// ----------------------------------------------------------------------------
interface hfo_req_if #(
   parameter int OFFSET_WIDTH = 24
) ();
   logic                           valid;
   logic                           ready;
   logic signed [OFFSET_WIDTH-1:0] x_offset;
   logic signed [OFFSET_WIDTH-1:0] y_offset;

   modport source (output valid, output x_offset, output y_offset, input ready);
   modport sink   (input valid, input x_offset, input y_offset, output ready);
endinterface

// ===== rtl/hfo_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hfo_rsp_if : response channel of the heading unit
// Valid/ready handshake carrying one heading in centidegrees.
// ----------------------------------------------------------------------------
interface hfo_rsp_if ();
   logic                                      valid;
   logic                                      ready;
   logic signed [hfo_pkg::HEADING_WIDTH-1:0]  heading_centideg;

   modport source (output valid, output heading_centideg, input ready);
   modport sink   (input valid, input heading_centideg, output ready);
endinterface

// ===== rtl/hfo_fold.sv =====
// ----------------------------------------------------------------------------
// hfo_fold : input stage
// Detect on-axis vectors, fold the left half plane and scale the offsets.
// ----------------------------------------------------------------------------
module hfo_fold #(
   parameter int OFFSET_WIDTH = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   hfo_req_if.sink                req,
   output logic                   out_valid,
   output hfo_pkg::hfo_stage_type out_data,
   input  logic                   out_ready
);
   localparam int SCALE_SHIFT = hfo_pkg::SCALED_MAG_LOG2 - OFFSET_WIDTH;
   localparam int EXT_BITS    = hfo_pkg::XY_WIDTH - OFFSET_WIDTH;

   logic                                 valid_ff;
   hfo_pkg::hfo_stage_type               data_ff;
   hfo_pkg::hfo_stage_type               data_in;
   logic signed [hfo_pkg::XY_WIDTH-1:0]  x_ext;
   logic signed [hfo_pkg::XY_WIDTH-1:0]  y_ext;
   logic                                 x_zero;
   logic                                 y_zero;
   logic                                 x_neg;
   logic                                 y_neg;

   assign x_ext  = {{EXT_BITS{req.x_offset[OFFSET_WIDTH-1]}}, req.x_offset};
   assign y_ext  = {{EXT_BITS{req.y_offset[OFFSET_WIDTH-1]}}, req.y_offset};
   assign x_zero = (req.x_offset == '0);
   assign y_zero = (req.y_offset == '0);
   assign x_neg  = req.x_offset[OFFSET_WIDTH-1];
   assign y_neg  = req.y_offset[OFFSET_WIDTH-1];

   always_comb begin
      data_in.special         = x_zero || y_zero;
      data_in.special_heading = hfo_pkg::HEADING_ZERO;
      if (x_zero && !y_zero) begin
         data_in.special_heading = y_neg ? hfo_pkg::NEG_QUARTER_TURN : hfo_pkg::QUARTER_TURN;
      end else if (y_zero && x_neg) begin
         data_in.special_heading = hfo_pkg::HALF_TURN;
      end

      // fold the left half plane by a half turn
      if (x_neg) begin
         data_in.x   = (-x_ext) <<< SCALE_SHIFT;
         data_in.y   = (-y_ext) <<< SCALE_SHIFT;
         data_in.acc = y_neg ? -hfo_pkg::ACC_HALF_TURN : hfo_pkg::ACC_HALF_TURN;
      end else begin
         data_in.x   = x_ext <<< SCALE_SHIFT;
         data_in.y   = y_ext <<< SCALE_SHIFT;
         data_in.acc = hfo_pkg::ACC_ZERO;
      end
   end

   assign req.ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req.ready) begin
         valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

// ===== rtl/hfo_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// hfo_cordic_stage : one vectoring micro-rotation
// Rotate toward the x axis by atan(2^-i) and register the result.
// ----------------------------------------------------------------------------
module hfo_cordic_stage #(
   parameter int STAGE_INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  hfo_pkg::hfo_stage_type in_data,
   output logic                   in_ready,
   output logic                   out_valid,
   output hfo_pkg::hfo_stage_type out_data,
   input  logic                   out_ready
);
   localparam logic [4:0] ATAN_INDEX = 5'(STAGE_INDEX);

   logic                                 valid_ff;
   hfo_pkg::hfo_stage_type               data_ff;
   hfo_pkg::hfo_stage_type               data_in;
   logic signed [hfo_pkg::XY_WIDTH-1:0]  x_shift;
   logic signed [hfo_pkg::XY_WIDTH-1:0]  y_shift;
   logic signed [hfo_pkg::ACC_WIDTH-1:0] angle_step;
   logic                                 y_pos;

   assign x_shift    = in_data.x >>> STAGE_INDEX;
   assign y_shift    = in_data.y >>> STAGE_INDEX;
   assign angle_step = hfo_pkg::atan_entry(ATAN_INDEX);
   assign y_pos      = !in_data.y[hfo_pkg::XY_WIDTH-1] && (in_data.y != '0);

   always_comb begin
      data_in = in_data;
      if (y_pos) begin
         data_in.x   = in_data.x + y_shift;
         data_in.y   = in_data.y - x_shift;
         data_in.acc = in_data.acc + angle_step;
      end else begin
         data_in.x   = in_data.x - y_shift;
         data_in.y   = in_data.y + x_shift;
         data_in.acc = in_data.acc - angle_step;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

// ===== rtl/hfo_round.sv =====
// ----------------------------------------------------------------------------
// hfo_round : output stage
// Round the accumulator to centidegrees, wrap and clamp, pick on-axis answers.
// ----------------------------------------------------------------------------
module hfo_round (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  hfo_pkg::hfo_stage_type in_data,
   output logic                   in_ready,
   hfo_rsp_if.source              rsp
);
   logic                                     valid_ff;
   logic signed [hfo_pkg::HEADING_WIDTH-1:0] heading_ff;
   logic signed [hfo_pkg::HEADING_WIDTH-1:0] heading_in;
   logic signed [hfo_pkg::ACC_WIDTH-1:0]     acc_rounded;
   logic signed [hfo_pkg::HEADING_WIDTH-1:0] rounded;

   assign acc_rounded = in_data.acc + hfo_pkg::ACC_ROUND;
   assign rounded     = acc_rounded[hfo_pkg::ACC_WIDTH-1:hfo_pkg::ANGLE_FRAC_BITS];

   always_comb begin
      if (in_data.special) begin
         heading_in = in_data.special_heading;
      end else if (rounded > hfo_pkg::HALF_TURN || rounded <= hfo_pkg::NEG_HALF_TURN) begin
         // clamp above a half turn; wrap the negative x axis onto +180
         heading_in = hfo_pkg::HALF_TURN;
      end else begin
         heading_in = rounded;
      end
   end

   assign in_ready = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         heading_ff <= heading_in;
      end
   end

   assign rsp.valid            = valid_ff;
   assign rsp.heading_centideg = heading_ff;
endmodule

// ===== rtl/heading_from_offset_atan2_unit.sv =====
// ----------------------------------------------------------------------------
// heading_from_offset_atan2_unit : four-quadrant heading by CORDIC
// Request: signed x_offset / y_offset pair. Response: heading_centideg,
// counterclockwise from +x, -17999 to 18000 hundredths of a degree.
//
// Usage:
//  - Both channels use valid/ready; a request moves on a clock edge where
//    valid and ready are both high.
//  - Each request passes through one fold stage, one register per
//    micro-rotation and one rounding stage.
//  - Throughput is one request per cycle while the response side is ready;
//    every stage holds one request and the adder chain is fully pipelined.
//  - When the response side stalls, each stage holds its request and
//    req.ready drops only once every stage from the output back is full;
//    empty stages keep filling, so nothing is dropped or repeated.
//  - Synchronous reset clears all valid bits; the data path holds no state
//    that outlives a request, so no setup is needed after reset.
//  - Vectors on an axis (and the zero vector, reported as 0) bypass the
//    rotation result and travel with the request as a flagged constant.
// ----------------------------------------------------------------------------
module heading_from_offset_atan2_unit #(
   parameter int CORDIC_ITERATIONS = 16,
   parameter int OFFSET_WIDTH      = 24
) (
   input logic       clock,
   input logic       reset,
   hfo_req_if.sink   req,
   hfo_rsp_if.source rsp
);
   // stage k feeds micro-rotation k; the last entry feeds the rounding stage
   hfo_pkg::hfo_stage_type         stage_data  [0:CORDIC_ITERATIONS];
   logic [CORDIC_ITERATIONS:0]     stage_valid;
   logic [CORDIC_ITERATIONS:0]     stage_ready;

   // fold left half plane, flag on-axis vectors, scale to the CORDIC format
   hfo_fold #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_fold (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (stage_valid[0]),
      .out_data  (stage_data[0]),
      .out_ready (stage_ready[0])
   );

   // one registered micro-rotation per iteration
   for (genvar k = 0; k < CORDIC_ITERATIONS; k++) begin : g_rotate
      hfo_cordic_stage #(
         .STAGE_INDEX (k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[k]),
         .in_data   (stage_data[k]),
         .in_ready  (stage_ready[k]),
         .out_valid (stage_valid[k+1]),
         .out_data  (stage_data[k+1]),
         .out_ready (stage_ready[k+1])
      );
   end

   // round to centidegrees, wrap and clamp, hold the response
   hfo_round u_round (
      .clock    (clock),
      .reset    (reset),
      .in_valid (stage_valid[CORDIC_ITERATIONS]),
      .in_data  (stage_data[CORDIC_ITERATIONS]),
      .in_ready (stage_ready[CORDIC_ITERATIONS]),
      .rsp      (rsp)
   );
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb : self-checking bench for heading_from_offset_atan2_unit
// Offset pairs go in through a table of directed cases and then randomized
// phases. Each accepted request is predicted in fixed point on the bench side
// and compared against the heading that comes out, with random gaps on both
// channels, a long output stall and a full drain along the way.
// ----------------------------------------------------------------------------
module tb;

   localparam int OFFSET_W       = 24;
   localparam int CORDIC_ITERS   = 16;
   localparam int RESET_CYCLES   = 11;
   localparam int LONG_HOLD      = 60;
   localparam int DRAIN_CYCLES   = 2 * (CORDIC_ITERS + 2) + 4;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = 24'sh7FFFFF;
   localparam logic signed [OFFSET_W-1:0] OFFSET_MIN = 24'sh800000;

   // Micro-rotation angles, atan(2^-i) in centidegrees scaled by 2^16.
   localparam longint ROT_ANGLE_Q16 [CORDIC_ITERS] = '{
      294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
      5866609, 2933484, 1466764, 733385, 366693, 183346,
      91673, 45837, 22918, 11459
   };

   typedef struct {
      logic signed [OFFSET_W-1:0]               x;
      logic signed [OFFSET_W-1:0]               y;
      bit                                       pinned;
      logic signed [hfo_pkg::HEADING_WIDTH-1:0] heading;
   } offset_row_type;

   logic clock;
   logic reset;

   hfo_req_if #(.OFFSET_WIDTH(OFFSET_W)) req_bus ();
   hfo_rsp_if                            rsp_bus ();

   heading_from_offset_atan2_unit #(
      .CORDIC_ITERATIONS (CORDIC_ITERS),
      .OFFSET_WIDTH      (OFFSET_W)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus.sink),
      .rsp   (rsp_bus.source)
   );

   // Requests offered but not yet taken, and headings still owed by the block.
   offset_row_type                           offered_q [$];
   logic signed [hfo_pkg::HEADING_WIDTH-1:0] heading_q [$];

   int unsigned error_count;
   int unsigned request_count;
   int unsigned result_count;
   int unsigned input_stall_cycles;
   int unsigned idle_cycles;
   int unsigned directed_count;

   // Knobs shared by the driving processes.
   bit send_eager;
   bit rsp_eager;
   bit long_hold_pending;

   offset_row_type directed_rows [24];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Predict the heading for one offset pair, bit for bit with the block's
   // fixed-point scheme: axis table first, then fold into the right half
   // plane and run the vectoring micro-rotations.
   function automatic logic signed [hfo_pkg::HEADING_WIDTH-1:0] heading_of_offset(
      input logic signed [OFFSET_W-1:0] xo,
      input logic signed [OFFSET_W-1:0] yo
   );
      longint cx;
      longint cy;
      longint angle;
      longint xs;
      longint ys;
      longint rounded;
      cx = xo;
      cy = yo;
      angle = 0;
      if (cx == 0 && cy == 0) return hfo_pkg::HEADING_ZERO;
      if (cx == 0) return (cy > 0) ? hfo_pkg::QUARTER_TURN : hfo_pkg::NEG_QUARTER_TURN;
      if (cy == 0) return (cx > 0) ? hfo_pkg::HEADING_ZERO : hfo_pkg::HALF_TURN;
      // Left half plane: rotate by a half turn and preload the angle.
      if (cx < 0) begin
         angle = ((cy > 0) ? 64'sd18000 : -64'sd18000) <<< hfo_pkg::ANGLE_FRAC_BITS;
         cx = -cx;
         cy = -cy;
      end
      cx = cx <<< (hfo_pkg::SCALED_MAG_LOG2 - OFFSET_W);
      cy = cy <<< (hfo_pkg::SCALED_MAG_LOG2 - OFFSET_W);
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (cy > 0) begin
            cx = cx + ys;
            cy = cy - xs;
            angle = angle + ROT_ANGLE_Q16[i];
         end else begin
            cx = cx - ys;
            cy = cy + xs;
            angle = angle - ROT_ANGLE_Q16[i];
         end
      end
      rounded = (angle + (64'sd1 <<< (hfo_pkg::ANGLE_FRAC_BITS - 1)))
                >>> hfo_pkg::ANGLE_FRAC_BITS;
      // Saturate above a half turn, wrap the cut along the negative x axis.
      if (rounded > 18000) rounded = 18000;
      if (rounded <= -18000) rounded = 18000;
      return rounded[hfo_pkg::HEADING_WIDTH-1:0];
   endfunction

   // Draw one random offset pair, weighted toward the interesting regions.
   function automatic offset_row_type random_offset_row();
      offset_row_type row;
      logic signed [OFFSET_W-1:0] mag;
      logic signed [OFFSET_W-1:0] corner [5];
      corner = '{OFFSET_MIN, OFFSET_MAX, -24'sd1, 24'sd0, 24'sd1};
      row.pinned = 1'b0;
      row.heading = hfo_pkg::HEADING_ZERO;
      row.x = OFFSET_W'($urandom);
      row.y = OFFSET_W'($urandom);
      case ($urandom_range(0, 7))
         0, 1: ;  // full-range pair as drawn
         2: begin
            row.x = OFFSET_W'($signed($urandom_range(0, 80)) - 40);
            row.y = OFFSET_W'($signed($urandom_range(0, 80)) - 40);
         end
         3: begin
            // Land on an axis.
            if ($urandom_range(0, 1)) row.x = '0;
            else row.y = '0;
         end
         4: begin
            // Hug the negative x axis, where the wrap lives.
            row.x = OFFSET_W'(-$signed({1'b0, $urandom_range(1, 8388608)}));
            row.y = OFFSET_W'($signed($urandom_range(0, 6)) - 3);
         end
         5: begin
            // Diagonals in any quadrant.
            mag = OFFSET_W'($urandom_range(1, 8388607));
            row.x = $urandom_range(0, 1) ? mag : -mag;
            row.y = $urandom_range(0, 1) ? mag : -mag;
         end
         6: begin
            row.x = corner[$urandom_range(0, 4)];
            row.y = corner[$urandom_range(0, 4)];
         end
         default: begin
            // Strongly unequal magnitudes.
            if ($urandom_range(0, 1)) row.y = row.y >>> $urandom_range(0, 23);
            else row.x = row.x >>> $urandom_range(0, 23);
         end
      endcase
      return row;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns  mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Offer one request, with a random gap ahead of it unless bursting.
   // Valid stays high on return so back-to-back requests never drop it.
   task automatic issue_offsets(input offset_row_type row);
      int unsigned gap;
      gap = send_eager ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      offered_q.push_back(row);
      req_bus.valid    <= 1'b1;
      req_bus.x_offset <= row.x;
      req_bus.y_offset <= row.y;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid and hold until every owed heading has come back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (heading_q.size() != 0 || offered_q.size() != 0);
   endtask

   // Predict on request acceptance, check on response acceptance.
   always @(posedge clock) begin : scoreboard
      offset_row_type row;
      logic signed [hfo_pkg::HEADING_WIDTH-1:0] want;
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            request_count++;
            if (offered_q.size() == 0) begin
               report_mismatch("request accepted with nothing offered");
            end else begin
               row = offered_q.pop_front();
               heading_q.push_back(row.pinned ? row.heading
                                   : heading_of_offset(req_bus.x_offset, req_bus.y_offset));
            end
         end
         if (req_bus.valid && !req_bus.ready) input_stall_cycles++;
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            result_count++;
            if (heading_q.size() == 0) begin
               report_mismatch($sformatf("heading %0d arrived with none owed",
                                         rsp_bus.heading_centideg));
            end else begin
               want = heading_q.pop_front();
               if (rsp_bus.heading_centideg !== want)
                  report_mismatch($sformatf("heading_centideg got %0d, expected %0d",
                                            rsp_bus.heading_centideg, want));
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
      end
   end

   // Response side: random holds per result, an eager stretch, and a long
   // hold on request that lets the pipeline fill and push back on the input.
   initial begin : response_sink
      int unsigned hold;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         hold = rsp_eager ? 0 : $urandom_range(0, 5);
         if (hold != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // End the run if nothing moves on either channel for too long.
   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("%0t ns  no handshake for %0d cycles, %0d headings still owed",
               $time, WATCHDOG_LIMIT, heading_q.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      error_count        = 0;
      request_count      = 0;
      result_count       = 0;
      input_stall_cycles = 0;
      idle_cycles        = 0;
      send_eager         = 1'b0;
      rsp_eager          = 1'b0;
      long_hold_pending  = 1'b0;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.x_offset <= '0;
      req_bus.y_offset <= '0;

      // Axis and zero cases carry their answer; the rest go to the predictor.
      directed_rows = '{
         '{24'sd0,     24'sd0,     1'b1, hfo_pkg::HEADING_ZERO},
         '{24'sd0,     24'sd1,     1'b1, hfo_pkg::QUARTER_TURN},
         '{24'sd0,     -24'sd1,    1'b1, hfo_pkg::NEG_QUARTER_TURN},
         '{24'sd1,     24'sd0,     1'b1, hfo_pkg::HEADING_ZERO},
         '{-24'sd1,    24'sd0,     1'b1, hfo_pkg::HALF_TURN},
         '{OFFSET_MAX, 24'sd0,     1'b1, hfo_pkg::HEADING_ZERO},
         '{OFFSET_MIN, 24'sd0,     1'b1, hfo_pkg::HALF_TURN},
         '{24'sd0,     OFFSET_MAX, 1'b1, hfo_pkg::QUARTER_TURN},
         '{24'sd0,     OFFSET_MIN, 1'b1, hfo_pkg::NEG_QUARTER_TURN},
         '{24'sd1,     24'sd1,     1'b0, hfo_pkg::HEADING_ZERO},
         '{-24'sd1,    24'sd1,     1'b0, hfo_pkg::HEADING_ZERO},
         '{-24'sd1,    -24'sd1,    1'b0, hfo_pkg::HEADING_ZERO},
         '{24'sd1,     -24'sd1,    1'b0, hfo_pkg::HEADING_ZERO},
         '{OFFSET_MAX, OFFSET_MAX, 1'b0, hfo_pkg::HEADING_ZERO},
         '{OFFSET_MIN, OFFSET_MIN, 1'b0, hfo_pkg::HEADING_ZERO},
         '{OFFSET_MIN, OFFSET_MAX, 1'b0, hfo_pkg::HEADING_ZERO},
         '{OFFSET_MAX, OFFSET_MIN, 1'b0, hfo_pkg::HEADING_ZERO},
         // Just below and above the negative x axis (wrap and saturation), then near the other axes.
         '{OFFSET_MIN, -24'sd1,    1'b0, hfo_pkg::HEADING_ZERO},
         '{OFFSET_MIN, 24'sd1,     1'b0, hfo_pkg::HEADING_ZERO},
         '{OFFSET_MAX, 24'sd1,     1'b0, hfo_pkg::HEADING_ZERO},
         '{OFFSET_MAX, -24'sd1,    1'b0, hfo_pkg::HEADING_ZERO},
         '{24'sd1,     OFFSET_MAX, 1'b0, hfo_pkg::HEADING_ZERO},
         '{-24'sd1,    OFFSET_MIN, 1'b0, hfo_pkg::HEADING_ZERO},
         '{-24'sd3,    -24'sd7,    1'b0, hfo_pkg::HEADING_ZERO}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      foreach (directed_rows[i]) issue_offsets(directed_rows[i]);
      directed_count = $size(directed_rows);

      // Random traffic with gaps on both sides.
      repeat (500) issue_offsets(random_offset_row());

      // Hold the sender until the block has emptied.
      drain_results();

      // No idling on either side: full-rate stretch.
      send_eager = 1'b1;
      rsp_eager  = 1'b1;
      repeat (300) issue_offsets(random_offset_row());

      // Stall the output for a long stretch while requests keep coming.
      rsp_eager = 1'b0;
      long_hold_pending = 1'b1;
      repeat (80) issue_offsets(random_offset_row());
      send_eager = 1'b0;

      drain_results();

      repeat (370) issue_offsets(random_offset_row());

      // Let the last headings come out, then watch for stragglers.
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d offset pairs (%0d from the table), %0d headings checked,",
               request_count, directed_count, result_count);
      $display("axis and wrap cases, full-rate bursts, %0d input backpressure cycles.",
               input_stall_cycles);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", error_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
